FILE: design/brf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants for the byte ring FIFO
// Request and response word layouts, request and status codes, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package brf_pkg;

   // request kinds
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_LINE  = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_ROOM = 2'd1;
   localparam logic [1:0] ST_NO_DATA = 2'd2;
   localparam logic [1:0] ST_NO_LINE = 2'd3;

   // line terminators
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // most bytes moved by one write or read word
   localparam logic [2:0] MAX_BYTES = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  byte_count;
      logic [31:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_data;
      logic [2:0]  data_bytes;
      logic        last;
      logic [6:0]  fill_level;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic       latch_req;
      logic       load_status;
      logic [1:0] status_code;
      logic       clear_res;
      logic       wr_step;
      logic       start_read;
      logic       read_run;
      logic       start_scan;
      logic       scan_run;
      logic       start_emit;
      logic       emit_run;
      logic       load_final;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       n_zero;
      logic       room_ok;
      logic       data_ok;
      logic       wr_last;
      logic       stream_done;
      logic       lf_hit;
      logic       out_free;
   } dp_sts_type;

endpackage

FILE: design/brf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/brf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_datapath: pointers, fill count, byte store and response register
// Executes controller commands: byte writes, streamed reads from the store
// with registered read data, the newline scan and the line emit pass.
// ----------------------------------------------------------------------------
module brf_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  brf_pkg::req_word_type req_data,
   input  brf_pkg::ctrl_cmd_type cmd,
   output brf_pkg::dp_sts_type   sts,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output brf_pkg::rsp_word_type rsp_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   // control state
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [1:0]       type_ff, type_in;
   logic [2:0]       n_ff, n_in;
   logic [31:0]      wdata_ff, wdata_in;
   logic [1:0]       idx_ff, idx_in;
   logic [PTR_W-1:0] iss_ptr_ff, iss_ptr_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [PTR_W-1:0] cons_ptr_ff, cons_ptr_in;
   logic [CNT_W-1:0] scanned_ff, scanned_in;
   logic [31:0]      acc_ff, acc_in;
   logic [2:0]       nbytes_ff, nbytes_in;
   logic [1:0]       status_ff, status_in;
   brf_pkg::rsp_word_type rsp_ff, rsp_in;

   // store ports
   logic             ram_wr_en;
   logic [7:0]       ram_wr_data;
   logic             ram_rd_en;
   logic [7:0]       ram_rd_data;

   // stream control
   logic             run;
   logic             out_free;
   logic             need_out;
   logic             stall;
   logic             adv;
   logic             issue;
   logic [2:0]       n_sat;
   logic [SUM_W-1:0] room_sum;

   brf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (iss_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // status toward the controller
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign room_sum = SUM_W'(count_ff) + SUM_W'(n_ff);

   always_comb begin
      sts             = '0;
      sts.req_type    = type_ff;
      sts.n_zero      = (n_ff == 3'd0);
      sts.room_ok     = (room_sum <= SUM_W'(DEPTH));
      sts.data_ok     = (CNT_W'(n_ff) <= count_ff);
      sts.wr_last     = ({1'b0, idx_ff} == (n_ff - 3'd1));
      sts.stream_done = (left_ff == '0) && !pend_ff;
      sts.lf_hit      = pend_ff && (ram_rd_data == brf_pkg::CH_LF);
      sts.out_free    = out_free;
   end

   // streaming read control: issue one address a cycle unless stalled, consume the byte from the registered read data
   assign run      = cmd.read_run || cmd.scan_run || cmd.emit_run;
   assign need_out = cmd.emit_run && pend_ff && (ram_rd_data != brf_pkg::CH_CR)
                     && (nbytes_ff != 3'd0);
   assign stall    = need_out && !out_free;
   assign adv      = run && !stall;
   assign issue    = adv && (left_ff != '0);
   assign ram_rd_en = issue;

   assign n_sat = (req_data.byte_count > brf_pkg::MAX_BYTES) ?
                  brf_pkg::MAX_BYTES : req_data.byte_count;

   assign ram_wr_en   = cmd.wr_step;
   assign ram_wr_data = wdata_ff[{idx_ff, 3'b000} +: 8];

   // next-state logic
   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      type_in      = type_ff;
      n_in         = n_ff;
      wdata_in     = wdata_ff;
      idx_in       = idx_ff;
      iss_ptr_in   = iss_ptr_ff;
      left_in      = left_ff;
      cons_ptr_in  = cons_ptr_ff;
      scanned_in   = scanned_ff;
      acc_in       = acc_ff;
      nbytes_in    = nbytes_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // latch the request word
      if (cmd.latch_req) begin
         type_in  = req_data.req_type;
         n_in     = n_sat;
         wdata_in = req_data.write_data;
         idx_in   = 2'd0;
      end

      if (cmd.load_status) begin
         status_in = cmd.status_code;
      end

      if (cmd.clear_res) begin
         acc_in    = '0;
         nbytes_in = 3'd0;
      end

      // one byte into the store
      if (cmd.wr_step) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
         idx_in    = idx_ff + 2'd1;
         count_in  = count_ff + CNT_W'(1);
      end

      // stream setup
      if (cmd.start_read) begin
         iss_ptr_in = rd_ptr_ff;
         left_in    = CNT_W'(n_ff);
         pend_in    = 1'b0;
         acc_in     = '0;
         idx_in     = 2'd0;
         nbytes_in  = n_ff;
      end

      if (cmd.start_scan) begin
         iss_ptr_in  = rd_ptr_ff;
         left_in     = count_ff;
         pend_in     = 1'b0;
         cons_ptr_in = rd_ptr_ff;
         scanned_in  = '0;
      end

      // newline found: consume the line now, then replay it for output
      if (cmd.start_emit) begin
         iss_ptr_in = rd_ptr_ff;
         left_in    = scanned_ff;
         pend_in    = 1'b0;
         rd_ptr_in  = ptr_next(cons_ptr_ff);
         count_in   = count_ff - scanned_ff - CNT_W'(1);
      end

      // stream step
      if (issue) begin
         iss_ptr_in = ptr_next(iss_ptr_ff);
         left_in    = left_ff - CNT_W'(1);
      end
      if (adv) begin
         pend_in = issue;
      end

      if (adv && pend_ff) begin
         if (cmd.read_run) begin
            acc_in[{idx_ff, 3'b000} +: 8] = ram_rd_data;
            idx_in    = idx_ff + 2'd1;
            rd_ptr_in = ptr_next(rd_ptr_ff);
            count_in  = count_ff - CNT_W'(1);
         end
         if (cmd.scan_run) begin
            cons_ptr_in = ptr_next(cons_ptr_ff);
            scanned_in  = scanned_ff + CNT_W'(1);
         end
         // line bytes: one held back so the final one can carry last
         if (cmd.emit_run && (ram_rd_data != brf_pkg::CH_CR)) begin
            if (need_out) begin
               rsp_in.status     = brf_pkg::ST_OK;
               rsp_in.read_data  = acc_ff;
               rsp_in.data_bytes = nbytes_ff;
               rsp_in.last       = 1'b0;
               rsp_in.fill_level = 7'(count_ff);
               rsp_valid_in      = 1'b1;
            end
            acc_in    = {24'd0, ram_rd_data};
            nbytes_in = 3'd1;
         end
      end

      // closing word of a request
      if (cmd.load_final) begin
         rsp_in.status     = status_ff;
         rsp_in.read_data  = acc_ff;
         rsp_in.data_bytes = nbytes_ff;
         rsp_in.last       = 1'b1;
         rsp_in.fill_level = 7'(count_ff);
         rsp_valid_in      = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      n_ff        <= n_in;
      wdata_ff    <= wdata_in;
      idx_ff      <= idx_in;
      iss_ptr_ff  <= iss_ptr_in;
      left_ff     <= left_in;
      cons_ptr_ff <= cons_ptr_in;
      scanned_ff  <= scanned_in;
      acc_ff      <= acc_in;
      nbytes_ff   <= nbytes_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // pointer distance must match the fill count
   logic [SUM_W-1:0] ptr_sum;
   logic [SUM_W-1:0] ptr_wrap;
   assign ptr_sum  = SUM_W'(rd_ptr_ff) + SUM_W'(count_ff);
   assign ptr_wrap = (ptr_sum >= SUM_W'(DEPTH)) ? ptr_sum - SUM_W'(DEPTH) : ptr_sum;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      PTR_W'(ptr_wrap) == wr_ptr_ff)
      else $error("pointers disagree with fill count");

   a_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.data_bytes != 3'd0 || rsp_ff.read_data == 32'd0) &&
                        (rsp_ff.status == brf_pkg::ST_OK || rsp_ff.data_bytes == 3'd0)))
      else $error("response data not consistent with byte count or status");

endmodule

FILE: design/brf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ctrl: request sequencer for the byte ring FIFO
// Takes one request word, checks it, then steps the datapath through a
// write, a read, or a newline scan and, if a newline is found, the line emit pass.
// ----------------------------------------------------------------------------
module brf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  brf_pkg::dp_sts_type   sts,
   output brf_pkg::ctrl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;
   localparam logic [2:0] S_RESULT = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.load_status = 1'b1;
            cmd.clear_res   = 1'b1;
            cmd.status_code = brf_pkg::ST_OK;
            unique case (sts.req_type)
               brf_pkg::REQ_WRITE: begin
                  if (!sts.room_ok) begin
                     cmd.status_code = brf_pkg::ST_NO_ROOM;
                     state_in        = S_RESULT;
                  end else if (sts.n_zero) begin
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
               brf_pkg::REQ_READ: begin
                  if (!sts.data_ok) begin
                     cmd.status_code = brf_pkg::ST_NO_DATA;
                     state_in        = S_RESULT;
                  end else begin
                     cmd.start_read = 1'b1;
                     state_in       = S_READ;
                  end
               end
               brf_pkg::REQ_LINE: begin
                  cmd.start_scan = 1'b1;
                  state_in       = S_SCAN;
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end
         S_WRITE: begin
            cmd.wr_step = 1'b1;
            if (sts.wr_last) begin
               state_in = S_RESULT;
            end
         end
         S_READ: begin
            if (sts.stream_done) begin
               state_in = S_RESULT;
            end else begin
               cmd.read_run = 1'b1;
            end
         end
         S_SCAN: begin
            if (sts.lf_hit) begin
               cmd.start_emit = 1'b1;
               state_in       = S_EMIT;
            end else if (sts.stream_done) begin
               cmd.load_status = 1'b1;
               cmd.status_code = brf_pkg::ST_NO_LINE;
               state_in        = S_RESULT;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.stream_done) begin
               state_in = S_RESULT;
            end else begin
               cmd.emit_run = 1'b1;
            end
         end
         S_RESULT: begin
            if (sts.out_free) begin
               cmd.load_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new word taken while a request is in progress");

   a_result_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && !sts.out_free) |=> (state_ff == S_RESULT))
      else $error("closing word dropped while the response register is full");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_step, cmd.read_run, cmd.scan_run, cmd.emit_run,
                cmd.start_emit, cmd.load_final}))
      else $error("conflicting datapath commands");

endmodule

FILE: design/byte_ring_fifo_with_line_read.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_line_read: circular byte FIFO with line read
// Byte writes and reads of up to 4 bytes, plus a line read that returns one
// response word per line byte, carriage returns dropped.
//
//   channel  handshake            payload                  direction
//   req      req_valid/req_ready  req_data (req_word_type) in
//   rsp      rsp_valid/rsp_ready  rsp_data (rsp_word_type) out
//
// A line read scans the stored bytes for a newline, then replays the line at
// one byte a cycle while the response register is free. The single read port
// of the byte store sets the pace: one byte per cycle unless stalled.
// Reset: synchronous; pointers and fill count clear, store contents undefined.
// Stalls: a full response register holds the line replay; a new request word
// is taken while the last response word still waits.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_line_read #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  brf_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output brf_pkg::rsp_word_type rsp_data
);

   brf_pkg::ctrl_cmd_type cmd;
   brf_pkg::dp_sts_type   sts;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for byte_ring_fifo_with_line_read
// A short table of directed words comes first: empty-store failures, zero and
// oversized byte counts, the unused request kind, plain and empty lines, and a
// read with no newline stored. Bursts of random words follow that fill, drain
// and mix traffic, under four idling phases. Every response word is checked
// against a byte-queue model of the store, or, for table rows that carry a
// response typed in by hand, against that typed response.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH       = 64;
   localparam int RAND_WORDS  = 47;    // random request words per idling phase, spare kind not counted
   localparam int BURST_LEN   = 12;    // words per traffic burst
   localparam int IDLE_LIMIT  = 2000;  // cycles with no word moving
   localparam int TAIL_CYCLES = 100;
   localparam int MAX_REPORTS = 10;

   localparam logic [1:0] REQ_SPARE = 2'd3;  // unused request kind

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_type;

   // one row of the directed table; typed rows carry their own response
   typedef struct packed {
      brf_pkg::req_word_type req;
      logic                  typed;
      brf_pkg::rsp_word_type rsp;
   } stim_row_type;

   localparam brf_pkg::rsp_word_type NO_RSP = '0;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   brf_pkg::req_word_type req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   brf_pkg::rsp_word_type rsp_data;

   // hand-typed response travelling with the word on the request port
   logic                  row_typed;
   brf_pkg::rsp_word_type row_rsp;

   int gap_pct;
   int stall_pct;

   logic [7:0]            stored_bytes[$];   // bytes held by the store, oldest first
   brf_pkg::rsp_word_type rsp_expect_q[$];
   stim_row_type          plan[$];

   int err_count;
   int word_count;
   int rsp_count;
   int line_byte_count;
   int peak_fill;
   int no_room_count;
   int no_line_count;
   int idle_cycles;

   byte_ring_fifo_with_line_read #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic brf_pkg::req_word_type mk_req(logic [1:0] kind, logic [2:0] cnt,
                                                    logic [31:0] data);
      brf_pkg::req_word_type w;
      w.req_type   = kind;
      w.byte_count = cnt;
      w.write_data = data;
      return w;
   endfunction

   function automatic brf_pkg::rsp_word_type mk_rsp(logic [1:0] st, logic [31:0] data,
                                                    logic [2:0] nbytes, logic fin,
                                                    logic [6:0] fill);
      brf_pkg::rsp_word_type r;
      r.status     = st;
      r.read_data  = data;
      r.data_bytes = nbytes;
      r.last       = fin;
      r.fill_level = fill;
      return r;
   endfunction

   // queue appends
   function automatic void expect_rsp(brf_pkg::rsp_word_type r);
      rsp_expect_q.insert(rsp_expect_q.size(), r);
   endfunction

   function automatic void store_byte(logic [7:0] b);
      stored_bytes.insert(stored_bytes.size(), b);
   endfunction

   function automatic void add_row(brf_pkg::req_word_type req, logic typed,
                                   brf_pkg::rsp_word_type rsp);
      stim_row_type row;
      row.req   = req;
      row.typed = typed;
      row.rsp   = rsp;
      plan.insert(plan.size(), row);
   endfunction

   // Store model: updates the byte queue and queues the response words
   // that one accepted request word produces.
   function automatic void model_request(brf_pkg::req_word_type w);
      int          cnt;
      int          scanned;
      int          i;
      logic        found;
      logic        have;
      logic [7:0]  pending_byte;
      logic [31:0] acc;
      logic [6:0]  fill;

      cnt = (w.byte_count > brf_pkg::MAX_BYTES) ? int'(brf_pkg::MAX_BYTES) :
                                                   int'(w.byte_count);
      case (w.req_type)
         brf_pkg::REQ_WRITE: begin
            if (DEPTH - stored_bytes.size() < cnt) begin
               no_room_count++;
               expect_rsp(mk_rsp(brf_pkg::ST_NO_ROOM, 32'h0, 3'd0, 1'b1,
                                 7'(stored_bytes.size())));
            end else begin
               for (i = 0; i < cnt; i++)
                  store_byte(w.write_data[8*i +: 8]);
               if (stored_bytes.size() > peak_fill)
                  peak_fill = stored_bytes.size();
               expect_rsp(mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1,
                                 7'(stored_bytes.size())));
            end
         end
         brf_pkg::REQ_READ: begin
            if (cnt > stored_bytes.size()) begin
               expect_rsp(mk_rsp(brf_pkg::ST_NO_DATA, 32'h0, 3'd0, 1'b1,
                                 7'(stored_bytes.size())));
            end else begin
               acc = '0;
               for (i = 0; i < cnt; i++)
                  acc[8*i +: 8] = stored_bytes.pop_front();
               expect_rsp(mk_rsp(brf_pkg::ST_OK, acc, 3'(cnt), 1'b1,
                                 7'(stored_bytes.size())));
            end
         end
         brf_pkg::REQ_LINE: begin
            // scan for the newline, never past what is stored
            scanned = 0;
            found   = 1'b0;
            while (!found && scanned < stored_bytes.size()) begin
               if (stored_bytes[scanned] == brf_pkg::CH_LF)
                  found = 1'b1;
               scanned++;
            end
            if (!found) begin
               no_line_count++;
               expect_rsp(mk_rsp(brf_pkg::ST_NO_LINE, 32'h0, 3'd0, 1'b1,
                                 7'(stored_bytes.size())));
            end else begin
               fill = 7'(stored_bytes.size() - scanned);
               have = 1'b0;
               pending_byte = '0;
               // one word per non-CR byte; hold one back so the final gets last
               for (i = 0; i < scanned - 1; i++) begin
                  if (stored_bytes[i] != brf_pkg::CH_CR) begin
                     if (have) begin
                        expect_rsp(mk_rsp(brf_pkg::ST_OK, {24'h0, pending_byte},
                                          3'd1, 1'b0, fill));
                        line_byte_count++;
                     end
                     pending_byte = stored_bytes[i];
                     have = 1'b1;
                  end
               end
               for (i = 0; i < scanned; i++)
                  void'(stored_bytes.pop_front());
               if (have) begin
                  expect_rsp(mk_rsp(brf_pkg::ST_OK, {24'h0, pending_byte},
                                    3'd1, 1'b1, fill));
                  line_byte_count++;
               end else begin
                  expect_rsp(mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, fill));
               end
            end
         end
         default: begin
            expect_rsp(mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1,
                              7'(stored_bytes.size())));
         end
      endcase
   endfunction

   // Random request word; the mode sets the mix of kinds.
   function automatic brf_pkg::req_word_type rand_req(traffic_mode_type mode);
      int          roll;
      int          i;
      logic [1:0]  kind;
      logic [2:0]  cnt;
      logic [31:0] data;

      roll = $urandom_range(99);
      case (mode)
         MODE_FILL:  kind = (roll < 88) ? brf_pkg::REQ_WRITE :
                            (roll < 94) ? brf_pkg::REQ_READ : brf_pkg::REQ_LINE;
         MODE_DRAIN: kind = (roll < 10) ? brf_pkg::REQ_WRITE :
                            (roll < 50) ? brf_pkg::REQ_READ :
                            (roll < 97) ? brf_pkg::REQ_LINE : REQ_SPARE;
         default:    kind = (roll < 40) ? brf_pkg::REQ_WRITE :
                            (roll < 65) ? brf_pkg::REQ_READ :
                            (roll < 95) ? brf_pkg::REQ_LINE : REQ_SPARE;
      endcase

      roll = $urandom_range(99);
      if (mode == MODE_FILL && roll < 60)
         cnt = brf_pkg::MAX_BYTES;
      else if (roll < 80)
         cnt = 3'($urandom_range(4, 1));
      else
         cnt = 3'($urandom_range(7, 0));

      // text bytes keep lines short; raw words toggle every data bit
      if ($urandom_range(99) < 60) begin
         for (i = 0; i < 4; i++) begin
            roll = $urandom_range(99);
            data[8*i +: 8] = (roll < 12) ? brf_pkg::CH_LF :
                             (roll < 22) ? brf_pkg::CH_CR :
                             8'($urandom_range(255));
         end
      end else begin
         data = $urandom;
      end
      return mk_req(kind, cnt, data);
   endfunction

   // Offer one word at the falling edge, hold it until taken.
   task automatic send_word(input brf_pkg::req_word_type w, input logic typed,
                            input brf_pkg::rsp_word_type want);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      row_typed <= typed;
      row_rsp   <= want;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Prediction on accept, checking of response words, and the watchdog
   always @(posedge clock) begin : scoreboard
      brf_pkg::rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            model_request(req_data);
            word_count++;
            // hand-typed rows are single-word responses: swap in the typed one
            if (row_typed) begin
               void'(rsp_expect_q.pop_back());
               expect_rsp(row_rsp);
            end
         end

         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (rsp_expect_q.size() == 0) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display({"%0t: unexpected response st=%0d data=%h ",
                            "bytes=%0d last=%0d fill=%0d"},
                           $realtime, rsp_data.status, rsp_data.read_data,
                           rsp_data.data_bytes, rsp_data.last, rsp_data.fill_level);
            end else begin
               want = rsp_expect_q.pop_front();
               if (rsp_data.status     !== want.status     ||
                   rsp_data.read_data  !== want.read_data  ||
                   rsp_data.data_bytes !== want.data_bytes ||
                   rsp_data.last       !== want.last       ||
                   rsp_data.fill_level !== want.fill_level) begin
                  err_count++;
                  if (err_count <= MAX_REPORTS)
                     $display({"%0t: response %0d mismatch: expected st=%0d data=%h ",
                               "bytes=%0d last=%0d fill=%0d, got st=%0d data=%h ",
                               "bytes=%0d last=%0d fill=%0d"},
                              $realtime, rsp_count, want.status, want.read_data,
                              want.data_bytes, want.last, want.fill_level,
                              rsp_data.status, rsp_data.read_data, rsp_data.data_bytes,
                              rsp_data.last, rsp_data.fill_level);
               end
            end
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles, %0d responses outstanding",
                     $realtime, IDLE_LIMIT, rsp_expect_q.size());
            $display("** byte_ring_fifo_with_line_read: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      traffic_mode_type      mode;
      brf_pkg::req_word_type w;
      int                    phase;
      int                    sent;
      int                    k;
      int                    roll;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      row_typed  = 1'b0;
      row_rsp    = '0;
      gap_pct    = 0;
      stall_pct  = 0;
      err_count  = 0;
      word_count = 0;
      rsp_count  = 0;
      line_byte_count = 0;
      peak_fill     = 0;
      no_room_count = 0;
      no_line_count = 0;
      idle_cycles   = 0;
      mode = MODE_MIX;

      // directed table: request word, typed flag, typed response
      // failures on an empty store
      add_row(mk_req(brf_pkg::REQ_LINE,  3'd0, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_NO_LINE, 32'h0, 3'd0, 1'b1, 7'd0));
      add_row(mk_req(brf_pkg::REQ_READ,  3'd1, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_NO_DATA, 32'h0, 3'd0, 1'b1, 7'd0));
      // zero counts and the unused kind move nothing
      add_row(mk_req(brf_pkg::REQ_READ,  3'd0, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd0));
      add_row(mk_req(brf_pkg::REQ_WRITE, 3'd0, 32'hFFFF_FFFF), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd0));
      add_row(mk_req(REQ_SPARE, 3'd7, 32'hFFFF_FFFF), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd0));
      // "AB\r\n" then a line read
      add_row(mk_req(brf_pkg::REQ_WRITE, 3'd4, 32'h0A0D_4241), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd4));
      add_row(mk_req(brf_pkg::REQ_LINE,  3'd0, 32'h0), 1'b0, NO_RSP);
      // "\n\r\r\n" with an oversized count: two empty lines
      add_row(mk_req(brf_pkg::REQ_WRITE, 3'd7, 32'h0A0D_0D0A), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd4));
      add_row(mk_req(brf_pkg::REQ_LINE,  3'd0, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd3));
      add_row(mk_req(brf_pkg::REQ_LINE,  3'd0, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd0));
      // three bytes, no newline
      add_row(mk_req(brf_pkg::REQ_WRITE, 3'd3, 32'hFF00_0D7F), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd3));
      add_row(mk_req(brf_pkg::REQ_LINE,  3'd0, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_NO_LINE, 32'h0, 3'd0, 1'b1, 7'd3));
      add_row(mk_req(brf_pkg::REQ_READ,  3'd4, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_NO_DATA, 32'h0, 3'd0, 1'b1, 7'd3));
      add_row(mk_req(brf_pkg::REQ_READ,  3'd3, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0000_0D7F, 3'd3, 1'b1, 7'd0));
      // all-ones bytes ended by a newline
      add_row(mk_req(brf_pkg::REQ_WRITE, 3'd4, 32'hFFFF_FFFF), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd4));
      add_row(mk_req(brf_pkg::REQ_WRITE, 3'd1, 32'h0000_000A), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd5));
      add_row(mk_req(brf_pkg::REQ_LINE,  3'd0, 32'h0), 1'b0, NO_RSP);
      // terminators read back as plain bytes
      add_row(mk_req(brf_pkg::REQ_WRITE, 3'd2, 32'h1234_0A0D), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd2));
      add_row(mk_req(brf_pkg::REQ_READ,  3'd2, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0000_0A0D, 3'd2, 1'b1, 7'd0));
      // oversized counts on zero bytes
      add_row(mk_req(brf_pkg::REQ_WRITE, 3'd5, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd0, 1'b1, 7'd4));
      add_row(mk_req(brf_pkg::REQ_READ,  3'd6, 32'h0), 1'b1,
              mk_rsp(brf_pkg::ST_OK, 32'h0, 3'd4, 1'b1, 7'd0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_word(plan[i].req, plan[i].typed, plan[i].rsp);

      // random bursts under each idling phase
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 53; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 53; end
            default: begin gap_pct = 37; stall_pct = 37; end
         endcase
         sent = 0;
         k    = 0;
         while (sent < RAND_WORDS) begin
            if (k % BURST_LEN == 0) begin
               roll = $urandom_range(99);
               mode = (roll < 45) ? MODE_FILL : (roll < 75) ? MODE_DRAIN : MODE_MIX;
            end
            w = rand_req(mode);
            send_word(w, 1'b0, NO_RSP);
            if (w.req_type != REQ_SPARE)
               sent++;
            k++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then watch a while for stray words
      while (rsp_expect_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d request words (%0d directed), %0d responses, %0d line bytes.",
               word_count, plan.size(), rsp_count, line_byte_count);
      $display("Fill peaked at %0d of %0d; %0d writes refused, %0d lines not found.",
               peak_fill, DEPTH, no_room_count, no_line_count);
      if (err_count == 0)
         $display("** byte_ring_fifo_with_line_read: PASSED **");
      else
         $display("** byte_ring_fifo_with_line_read: FAILED **");
      $finish;
   end

endmodule
